// ----- sv/mafs_pkg.sv -----
`default_nettype none
package mafs_pkg;

  localparam int unsigned LEN_W      = 13;
  localparam int unsigned KBPS_W     = 9;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [7:0]        SYNC_BYTE   = 8'hFF;
  localparam logic [7:0]        SYNC_MASK   = 8'hF0;
  localparam logic [17:0]       FRAME_SCALE = 18'd144000;
  localparam logic [LEN_W-1:0]  LEN_MAX     = 13'd8191;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       pes_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             frame_first;
    logic             frame_last;
    logic             frame_error;
    logic [LEN_W-1:0] locked_length;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_HOLD,
    MODE_FRAME
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SECOND,
    ST_MUL,
    ST_DIV,
    ST_LOCK
  } state_t;

  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_FRAME,
    KIND_SYNC,
    KIND_HEADER
  } kind_t;

  typedef struct packed {
    logic take;
    logic second;
    logic mul_load;
    logic div_step;
    logic lock_emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  hdr_bad;
    logic  div_done;
  } status_t;

  localparam logic [KBPS_W-1:0] KBPS_ROW1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [KBPS_W-1:0] KBPS_ROW2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [KBPS_W-1:0] KBPS_ROW3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [KBPS_W-1:0] KBPS_ROW4 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [KBPS_W-1:0] KBPS_ROW5 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Bitrate in kbit/s from version, layer and bitrate index; 0 when invalid.
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [1:0] ver,
                                                     input logic [1:0] lay,
                                                     input logic [3:0] idx);
    logic [KBPS_W-1:0] v;
    v = '0;
    if (lay != 2'd0) begin
      case (ver)
        2'd3: begin
          case (lay)
            2'd3:    v = KBPS_ROW1[idx];
            2'd2:    v = KBPS_ROW2[idx];
            default: v = KBPS_ROW3[idx];
          endcase
        end
        2'd0, 2'd2: begin
          if (lay == 2'd3) begin
            v = KBPS_ROW4[idx];
          end else begin
            v = KBPS_ROW5[idx];
          end
        end
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // Sample rate in Hz from version and rate index; 0 when reserved.
  function automatic logic [RATE_W-1:0] rate_lookup(input logic [1:0] ver,
                                                    input logic [1:0] idx);
    logic [RATE_W-1:0] v;
    v = '0;
    case ({ver, idx})
      4'b0000: v = 16'd11025;
      4'b0001: v = 16'd12000;
      4'b0010: v = 16'd8000;
      4'b1000: v = 16'd22050;
      4'b1001: v = 16'd24000;
      4'b1010: v = 16'd16000;
      4'b1100: v = 16'd44100;
      4'b1101: v = 16'd48000;
      4'b1110: v = 16'd32000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mafs_stream_if.sv -----
`default_nettype none
interface mafs_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/mafs_controller.sv -----
`default_nettype none
module mafs_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mafs_pkg::status_t status,
  output mafs_pkg::cmd_t        cmd
);

  mafs_pkg::state_t state;
  mafs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mafs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      mafs_pkg::ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.take = 1'b1;
          case (status.kind)
            mafs_pkg::KIND_SYNC:   state_next = mafs_pkg::ST_SECOND;
            mafs_pkg::KIND_HEADER: state_next = mafs_pkg::ST_MUL;
            default:               state_next = mafs_pkg::ST_IDLE;
          endcase
        end
      end
      mafs_pkg::ST_SECOND: begin
        if (status.out_free) begin
          cmd.second = 1'b1;
          state_next = mafs_pkg::ST_IDLE;
        end
      end
      mafs_pkg::ST_MUL: begin
        // skip the divide on a bad header
        if (status.hdr_bad) begin
          state_next = mafs_pkg::ST_LOCK;
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = mafs_pkg::ST_DIV;
        end
      end
      mafs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = mafs_pkg::ST_LOCK;
        end
      end
      mafs_pkg::ST_LOCK: begin
        if (status.out_free) begin
          cmd.lock_emit = 1'b1;
          state_next    = mafs_pkg::ST_IDLE;
        end
      end
      default: state_next = mafs_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mafs_datapath.sv -----
`default_nettype none
module mafs_datapath #(
  parameter int unsigned MAX_FRAME_BYTES = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mafs_pkg::in_item_t  in_item,
  input  wire mafs_pkg::cmd_t      cmd,
  output mafs_pkg::status_t        status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mafs_pkg::out_item_t      out_item
);

  localparam int unsigned LW = mafs_pkg::LEN_W;
  localparam int unsigned DW = mafs_pkg::DIVIDEND_W;
  localparam int unsigned RW = mafs_pkg::RATE_W;
  localparam int unsigned CapInt = (MAX_FRAME_BYTES < 8191) ? MAX_FRAME_BYTES : 8191;
  localparam logic [LW-1:0] LEN_CAP = CapInt[LW-1:0];

  mafs_pkg::mode_t               mode;
  logic [LW-1:0]                 position;
  logic [LW-1:0]                 frame_length;
  logic                          length_locked;
  logic [7:0]                    header_second;
  logic [7:0]                    hold_byte;
  logic [mafs_pkg::KBPS_W-1:0]   kbps;
  logic [RW-1:0]                 rate;
  logic [RW-1:0]                 rem;
  logic [DW-1:0]                 dq;
  logic [mafs_pkg::DIV_CNT_W-1:0] count;

  // input classification
  logic [7:0]      b;
  logic            ps;
  mafs_pkg::mode_t mode_eff;
  mafs_pkg::mode_t mode_drop;
  mafs_pkg::kind_t kind;

  assign b  = in_item.data_byte;
  assign ps = in_item.pes_start;

  always_comb begin
    mode_eff = mode;
    if (mode == mafs_pkg::MODE_FRAME && position == '0 && ps) begin
      mode_eff = mafs_pkg::MODE_HUNT;
    end
    mode_drop = (b == mafs_pkg::SYNC_BYTE) ? mafs_pkg::MODE_HOLD : mafs_pkg::MODE_HUNT;
    case (mode_eff)
      mafs_pkg::MODE_HOLD: begin
        if (ps || (b & mafs_pkg::SYNC_MASK) != mafs_pkg::SYNC_MASK) begin
          kind = mafs_pkg::KIND_DROP;
        end else begin
          kind = mafs_pkg::KIND_SYNC;
        end
        if (!ps) begin
          mode_drop = mafs_pkg::MODE_HUNT;
        end
      end
      mafs_pkg::MODE_FRAME: begin
        if (position == LW'(2) && !length_locked) begin
          kind = mafs_pkg::KIND_HEADER;
        end else begin
          kind = mafs_pkg::KIND_FRAME;
        end
      end
      default: kind = mafs_pkg::KIND_DROP;
    endcase
  end

  // lock length from the divider result
  logic [DW:0]   len_raw;
  logic [LW-1:0] len_new;
  assign len_raw = {1'b0, dq} + {{DW{1'b0}}, hold_byte[1]};
  assign len_new = (len_raw > {{(DW+1-LW){1'b0}}, LEN_CAP}) ? LEN_CAP : len_raw[LW-1:0];

  // shared frame byte logic
  logic [7:0]    byte_sel;
  logic [LW-1:0] pos_sel;
  logic [LW-1:0] len_sel;
  logic          lock_sel;
  logic [LW:0]   pos_plus;
  logic          fb_last;
  logic [LW-1:0] pos_next;

  always_comb begin
    if (cmd.take) begin
      byte_sel = (kind == mafs_pkg::KIND_SYNC) ? mafs_pkg::SYNC_BYTE : b;
    end else begin
      byte_sel = hold_byte;
    end
    pos_sel  = (cmd.take && kind == mafs_pkg::KIND_SYNC) ? '0 : position;
    len_sel  = cmd.lock_emit ? len_new : frame_length;
    lock_sel = cmd.lock_emit | length_locked;
    pos_plus = {1'b0, pos_sel} + {{LW{1'b0}}, 1'b1};
    fb_last  = lock_sel && (pos_plus >= {1'b0, len_sel});
    pos_next = fb_last ? '0 : pos_plus[LW-1:0];
  end

  logic hdr_bad;
  assign hdr_bad = (kbps == '0) || (rate == '0);

  logic fb_exec;
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign fb_exec  = (cmd.take && (kind == mafs_pkg::KIND_FRAME || kind == mafs_pkg::KIND_SYNC))
                 || cmd.second || (cmd.lock_emit && !hdr_bad);

  // one restoring divide step
  logic [RW:0] rem_shift;
  logic [RW:0] rem_diff;
  logic        q_bit;
  assign rem_shift = {rem, dq[DW-1]};
  assign rem_diff  = rem_shift - {1'b0, rate};
  assign q_bit     = rem_shift >= {1'b0, rate};

  logic [26:0] product;
  assign product = {9'd0, mafs_pkg::FRAME_SCALE} * {18'd0, kbps};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= mafs_pkg::MODE_HUNT;
      position      <= '0;
      frame_length  <= '0;
      length_locked <= 1'b0;
      header_second <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.take) begin
        case (kind)
          mafs_pkg::KIND_DROP:   mode <= mode_drop;
          mafs_pkg::KIND_HEADER: hold_byte <= b;
          mafs_pkg::KIND_SYNC:   hold_byte <= b;
          default:               ;
        endcase
        if (kind == mafs_pkg::KIND_HEADER) begin
          kbps <= mafs_pkg::kbps_lookup(header_second[4:3], header_second[2:1], b[7:4]);
          rate <= mafs_pkg::rate_lookup(header_second[4:3], b[3:2]);
        end
      end
      if (fb_exec) begin
        position <= pos_next;
        mode     <= mafs_pkg::MODE_FRAME;
        if (pos_sel == LW'(1)) begin
          header_second <= byte_sel;
        end
      end
      if (cmd.lock_emit) begin
        if (hdr_bad) begin
          mode     <= mafs_pkg::MODE_HUNT;
          position <= '0;
        end else begin
          frame_length  <= len_new;
          length_locked <= 1'b1;
        end
      end
      if (fb_exec || cmd.lock_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath payload: output register and divider
  always_ff @(posedge clk) begin
    if (cmd.lock_emit && hdr_bad) begin
      out_item.out_byte      <= hold_byte;
      out_item.frame_first   <= 1'b0;
      out_item.frame_last    <= 1'b1;
      out_item.frame_error   <= 1'b1;
      out_item.locked_length <= '0;
    end else if (fb_exec) begin
      out_item.out_byte      <= byte_sel;
      out_item.frame_first   <= (pos_sel == '0);
      out_item.frame_last    <= fb_last;
      out_item.frame_error   <= 1'b0;
      out_item.locked_length <= lock_sel ? len_sel : '0;
    end
    if (cmd.mul_load) begin
      dq    <= product[DW-1:0];
      rem   <= '0;
      count <= '0;
    end else if (cmd.div_step) begin
      rem   <= q_bit ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
      dq    <= {dq[DW-2:0], q_bit};
      count <= count + 1'b1;
    end
  end

  assign status.kind     = kind;
  assign status.out_free = out_free;
  assign status.hdr_bad  = hdr_bad;
  assign status.div_done = (count == mafs_pkg::DIV_CNT_W'(DW - 1));

endmodule
`default_nettype wire

// ----- sv/mpeg_audio_frame_splitter.sv -----
`default_nettype none
// MPEG audio frame splitter. Feed it elementary-stream bytes of MPEG audio, each
// flagged with pes_start when it opens a PES payload; it returns only the bytes
// that belong to audio frames, marked on the first and last byte of each frame.
// On a payload start that falls on a frame boundary it hunts for sync (0xFF,
// then a byte with high nibble 0xF) and drops everything before it. The first
// header fixes the frame length for good as 144000 * kbps / rate + padding,
// capped at MAX_FRAME_BYTES and at 8191; later frames are cut at that length
// without looking at their headers. A header with a zero bitrate or sample rate
// ends the frame on its third byte with frame_error and goes back to hunting.
// Throughput: one byte per cycle in steady state. A sync byte pair leaves
// through the single output register. The one-time lock on the first header
// runs a table lookup, one multiply and a 26-step restoring divider that
// produces one quotient bit per cycle. Input ready follows the output
// register, so a stalled output holds the input. Reset is synchronous; no
// clearing pass.
module mpeg_audio_frame_splitter #(
  parameter int unsigned MAX_FRAME_BYTES = 8192
) (
  input wire logic      clk,
  input wire logic      rst,
  mafs_stream_if.sink   in_ch,
  mafs_stream_if.source out_ch
);

  mafs_pkg::cmd_t      cmd;
  mafs_pkg::status_t   status;
  mafs_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  // sequence accept, sync pair, header lock
  mafs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // stream state, length divider and output register
  mafs_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_ch.payload),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule
`default_nettype wire

// ----- sv/mafs_checker.sv -----
`default_nettype none
module mafs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mafs_pkg::out_item_t out_item
);

  logic                      seen;
  logic [mafs_pkg::LEN_W-1:0] lock_len;

  // remember the length once an item shows it locked
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      lock_len <= '0;
    end else if (out_valid && out_ready && !seen && out_item.locked_length != '0) begin
      seen     <= 1'b1;
      lock_len <= out_item.locked_length;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_error |->
      out_item.frame_last && !out_item.frame_first && out_item.locked_length == '0)
    else $error("error item without last mark or with a length");

  a_lock_stays: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen |-> !out_item.frame_error && out_item.locked_length == lock_len)
    else $error("locked length changed after lock");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_in_gate: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input accepted with output full");

endmodule

bind mpeg_audio_frame_splitter mafs_checker u_mafs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);
`default_nettype wire
